[rtl/core/ahvm_pkg.sv]
// Shared types and constants of the heater and voltage monitor.
`timescale 1ns / 1ps
package ahvm_pkg;

	localparam int ADC_W       = 10;
	localparam int SUM_W       = 20;
	localparam int CNT_W       = 10;
	localparam int CFG_W       = 20;
	localparam int CFG_IDX_W   = 2;
	localparam int DIV_N_W     = 20;
	localparam int DIV_D_W     = 11;
	localparam int DIV_CNT_W   = $clog2(DIV_N_W);
	localparam int SLOT_W      = 4;
	localparam int SLOT_COUNT  = 10;
	localparam int TEMP_W      = 11;
	localparam int VOLT_W      = 16;
	localparam int TREE_LEVELS = 16;
	localparam int TREE_CNT_W  = 16;
	localparam int LVL_W       = $clog2(TREE_LEVELS);
	localparam int PAIRS       = 2 * TREE_LEVELS;
	localparam int PAIR_IDX_W  = $clog2(PAIRS);
	localparam int TEMP_PROD_W = 35;
	localparam int TEMP_SHIFT  = 24;

	localparam logic [SLOT_W-1:0] SLOT_HEAT_A = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_HEAT_B = SLOT_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_TEMP   = SLOT_W'(2);
	localparam logic [SLOT_W-1:0] SLOT_VOLT   = SLOT_W'(SLOT_COUNT - 1);

	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_THRESHOLD    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_VOLTAGE_NUMERATOR = CFG_IDX_W'(2);

	localparam logic [ADC_W-1:0]   KEEP_THRESHOLD_RST    = ADC_W'(30);
	localparam logic [CNT_W-1:0]   AVERAGE_COUNT_RST     = CNT_W'(480);
	localparam logic [CFG_W-1:0]   VOLTAGE_NUMERATOR_RST = CFG_W'(112530);

	// (t*107+780)/100 as one multiply by 107*ceil(2^24/100) plus 780*ceil(2^24/100), then >> 24
	localparam logic [TEMP_PROD_W-1:0] TEMP_MUL = TEMP_PROD_W'(17951711);
	localparam logic [TEMP_PROD_W-1:0] TEMP_ADD = TEMP_PROD_W'(130862940);
	localparam logic [TEMP_W-1:0]      TEMP_RST = TEMP_W'(780 / 100);

	localparam logic [VOLT_W-1:0] VOLT_MAX   = '1;
	localparam logic [VOLT_W-1:0] PAIR_RESET = VOLT_W'(65278);

	typedef enum logic [1:0] {
		STAGE_OFF    = 2'd0,
		STAGE_KEEP   = 2'd1,
		STAGE_SINGLE = 2'd2,
		STAGE_DOUBLE = 2'd3
	} stage_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV_WAIT,
		ST_TREE,
		ST_CLASSIFY,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIV_N_W-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic              start;
		logic [VOLT_W-1:0] value;
	} tree_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [VOLT_W-1:0] minimum;
	} tree_rsp_t;

endpackage

[rtl/core/ahvm_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ahvm_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  ahvm_pkg::div_req_t  req,
	output ahvm_pkg::div_rsp_t  rsp
);

	logic [ahvm_pkg::DIV_D_W-1:0]   rem_q;
	logic [ahvm_pkg::DIV_N_W-1:0]   quo_q;
	logic [ahvm_pkg::DIV_D_W-1:0]   dsr_q;
	logic [ahvm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [ahvm_pkg::DIV_D_W:0]     partial;
	logic [ahvm_pkg::DIV_D_W:0]     diff;
	logic                           fits;

	assign partial = {rem_q, quo_q[ahvm_pkg::DIV_N_W-1]};
	assign diff    = partial - {1'b0, dsr_q};
	assign fits    = partial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ahvm_pkg::DIV_CNT_W'(ahvm_pkg::DIV_N_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[ahvm_pkg::DIV_D_W-1:0] : partial[ahvm_pkg::DIV_D_W-1:0];
			quo_q <= {quo_q[ahvm_pkg::DIV_N_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[rtl/core/ahvm_min_tree.sv]
// Binary minimum tree, one level per cycle, giving the sliding minimum.
`timescale 1ns / 1ps
module ahvm_min_tree (
	input  logic                clk,
	input  logic                arst_n,
	input  ahvm_pkg::tree_req_t req,
	output ahvm_pkg::tree_rsp_t rsp
);

	logic [ahvm_pkg::VOLT_W-1:0]     pairs_q [ahvm_pkg::PAIRS];
	logic [ahvm_pkg::TREE_CNT_W-1:0] counter_q;
	logic [ahvm_pkg::TREE_CNT_W-1:0] c_q;
	logic [ahvm_pkg::LVL_W-1:0]      lvl_q;
	logic [ahvm_pkg::VOLT_W-1:0]     v_q;
	logic [ahvm_pkg::VOLT_W-1:0]     min_q;
	logic                            busy_q;
	logic                            done_q;
	logic                            side;
	logic [ahvm_pkg::PAIR_IDX_W-1:0] wr_idx;
	logic [ahvm_pkg::PAIR_IDX_W-1:0] sib_idx;
	logic [ahvm_pkg::VOLT_W-1:0]     sib;
	logic [ahvm_pkg::VOLT_W-1:0]     v_next;

	assign side    = c_q[lvl_q];
	assign wr_idx  = {lvl_q, side};
	assign sib_idx = {lvl_q, ~side};
	assign sib     = pairs_q[sib_idx];
	assign v_next  = (v_q < sib) ? v_q : sib;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ahvm_pkg::PAIRS; i++) begin
				pairs_q[i] <= ahvm_pkg::PAIR_RESET;
			end
			counter_q <= '0;
			min_q     <= '0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			lvl_q     <= '0;
			c_q       <= '0;
			v_q       <= '0;
		end else if (req.start) begin
			c_q       <= counter_q;
			counter_q <= counter_q + 1'b1;
			v_q       <= req.value;
			lvl_q     <= '0;
			busy_q    <= 1'b1;
			done_q    <= 1'b0;
		end else if (busy_q) begin
			pairs_q[wr_idx] <= v_q;
			v_q             <= v_next;
			lvl_q           <= lvl_q + 1'b1;
			if (lvl_q == ahvm_pkg::LVL_W'(ahvm_pkg::TREE_LEVELS - 1)) begin
				min_q  <= v_next;
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.minimum = min_q;

endmodule

[rtl/core/adc_heater_voltage_monitor_unit.sv]
// Top level of the heater and supply voltage monitor: sequencer, state and result register.
`timescale 1ns / 1ps
// One converter sample is taken per transfer and one result is returned per sample. A
// sample that is dropped, latches the temperature or adds to a first heater channel block
// passes through the execute and finish states, and a second heater channel sample also
// passes the classify state, which classifies the stage. A heater sample that closes its
// block average also waits for the shared 20-bit divider, which produces one quotient bit
// per cycle. A supply voltage sample runs the divider followed by the 16-level minimum tree
// that is walked one level per cycle, and skips the division when the sample is zero. The
// result becomes valid in the same cycle that the next sample can be taken. The sample port
// is not ready while an item is in work; a finished result waits in the output register and
// does not hold off the next sample unless a second result is ready before it has been taken.
module adc_heater_voltage_monitor_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ahvm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [ahvm_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  sample_valid,
	output logic                                  sample_ready,
	input  logic [ahvm_pkg::ADC_W-1:0]            adc_sample,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic [ahvm_pkg::SLOT_W-1:0]           sample_slot,
	output logic [1:0]                            heater_stage,
	output logic [ahvm_pkg::ADC_W-1:0]            heater_avg_a,
	output logic [ahvm_pkg::ADC_W-1:0]            heater_avg_b,
	output logic [ahvm_pkg::TEMP_W-1:0]           temperature,
	output logic [ahvm_pkg::VOLT_W-1:0]           min_voltage
);

	ahvm_pkg::state_t state_q, state_d;

	logic [ahvm_pkg::ADC_W-1:0]  keep_threshold_q;
	logic [ahvm_pkg::CNT_W-1:0]  average_count_q;
	logic [ahvm_pkg::CFG_W-1:0]  voltage_numerator_q;

	logic [ahvm_pkg::SLOT_W-1:0] slot_index_q;
	logic [ahvm_pkg::SLOT_W-1:0] slot_q;
	logic [ahvm_pkg::ADC_W-1:0]  sample_q;
	logic [ahvm_pkg::SUM_W-1:0]  sum_a_q, sum_b_q;
	logic [ahvm_pkg::CNT_W-1:0]  count_a_q, count_b_q;
	logic [ahvm_pkg::ADC_W-1:0]  avg_a_q, avg_b_q;
	ahvm_pkg::stage_t            committed_q, pending_q;
	logic [ahvm_pkg::TEMP_W-1:0] temp_q;

	logic                        result_valid_q;
	logic [ahvm_pkg::SLOT_W-1:0] out_slot_q;
	ahvm_pkg::stage_t            out_stage_q;
	logic [ahvm_pkg::ADC_W-1:0]  out_avg_a_q, out_avg_b_q;
	logic [ahvm_pkg::TEMP_W-1:0] out_temp_q;
	logic [ahvm_pkg::VOLT_W-1:0] out_volt_q;

	ahvm_pkg::div_req_t  div_req;
	ahvm_pkg::div_rsp_t  div_rsp;
	ahvm_pkg::tree_req_t tree_req;
	ahvm_pkg::tree_rsp_t tree_rsp;

	logic                        is_b;
	logic [ahvm_pkg::SUM_W-1:0]  sum_new;
	logic [ahvm_pkg::CNT_W-1:0]  cnt_new;
	logic                        block_done;
	logic [ahvm_pkg::DIV_D_W-1:0] block_n;
	logic [ahvm_pkg::VOLT_W-1:0] volt_value;
	logic [ahvm_pkg::TEMP_PROD_W-1:0] temp_prod;
	ahvm_pkg::stage_t            stage_new;
	logic                        accept;
	logic                        load;
	logic [ahvm_pkg::SLOT_W:0]   slot_inc;

	assign accept       = sample_valid && sample_ready;
	assign sample_ready = (state_q == ahvm_pkg::ST_IDLE);
	assign load         = (state_q == ahvm_pkg::ST_FINISH) && (!result_valid_q || result_ready);
	assign slot_inc     = {1'b0, slot_q} + 1'b1;

	assign is_b       = (slot_q == ahvm_pkg::SLOT_HEAT_B);
	assign sum_new    = (is_b ? sum_b_q : sum_a_q) + ahvm_pkg::SUM_W'(sample_q);
	assign cnt_new    = (is_b ? count_b_q : count_a_q) + 1'b1;
	assign block_done = (cnt_new == '0) || (cnt_new >= average_count_q);
	assign block_n    = {(cnt_new == '0), cnt_new};

	assign temp_prod  = ahvm_pkg::TEMP_PROD_W'(sample_q) * ahvm_pkg::TEMP_MUL
		+ ahvm_pkg::TEMP_ADD;

	assign volt_value = (|div_rsp.quotient[ahvm_pkg::DIV_N_W-1:ahvm_pkg::VOLT_W])
		? ahvm_pkg::VOLT_MAX : div_rsp.quotient[ahvm_pkg::VOLT_W-1:0];

	always_comb begin
		if (avg_a_q == '0 && avg_b_q == '0) begin
			stage_new = ahvm_pkg::STAGE_OFF;
		end else if (avg_a_q < keep_threshold_q && avg_b_q < keep_threshold_q) begin
			stage_new = ahvm_pkg::STAGE_KEEP;
		end else if (avg_a_q == '0 || avg_b_q == '0) begin
			stage_new = ahvm_pkg::STAGE_SINGLE;
		end else begin
			stage_new = ahvm_pkg::STAGE_DOUBLE;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ahvm_pkg::ST_IDLE: begin
				if (sample_valid) state_d = ahvm_pkg::ST_EXEC;
			end
			ahvm_pkg::ST_EXEC: begin
				case (slot_q)
					ahvm_pkg::SLOT_HEAT_A: begin
						state_d = block_done ? ahvm_pkg::ST_DIV_WAIT : ahvm_pkg::ST_FINISH;
					end
					ahvm_pkg::SLOT_HEAT_B: begin
						state_d = block_done ? ahvm_pkg::ST_DIV_WAIT : ahvm_pkg::ST_CLASSIFY;
					end
					ahvm_pkg::SLOT_VOLT: begin
						state_d = (sample_q == '0) ? ahvm_pkg::ST_TREE : ahvm_pkg::ST_DIV_WAIT;
					end
					default: state_d = ahvm_pkg::ST_FINISH;
				endcase
			end
			ahvm_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					case (slot_q)
						ahvm_pkg::SLOT_HEAT_B: state_d = ahvm_pkg::ST_CLASSIFY;
						ahvm_pkg::SLOT_VOLT:   state_d = ahvm_pkg::ST_TREE;
						default:               state_d = ahvm_pkg::ST_FINISH;
					endcase
				end
			end
			ahvm_pkg::ST_TREE: begin
				if (tree_rsp.done) state_d = ahvm_pkg::ST_FINISH;
			end
			ahvm_pkg::ST_CLASSIFY: state_d = ahvm_pkg::ST_FINISH;
			ahvm_pkg::ST_FINISH: begin
				if (load) state_d = ahvm_pkg::ST_IDLE;
			end
			default: state_d = ahvm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		tree_req.start   = 1'b0;
		tree_req.value   = '0;
		case (state_q)
			ahvm_pkg::ST_EXEC: begin
				case (slot_q)
					ahvm_pkg::SLOT_HEAT_A, ahvm_pkg::SLOT_HEAT_B: begin
						div_req.start    = block_done;
						div_req.dividend = sum_new;
						div_req.divisor  = block_n;
					end
					ahvm_pkg::SLOT_VOLT: begin
						div_req.start    = (sample_q != '0);
						div_req.dividend = voltage_numerator_q;
						div_req.divisor  = ahvm_pkg::DIV_D_W'(sample_q);
						tree_req.start   = (sample_q == '0);
						tree_req.value   = ahvm_pkg::VOLT_MAX;
					end
					default: begin
						div_req.start = 1'b0;
					end
				endcase
			end
			ahvm_pkg::ST_DIV_WAIT: begin
				tree_req.start = div_rsp.done && (slot_q == ahvm_pkg::SLOT_VOLT);
				tree_req.value = volt_value;
			end
			default: begin
				tree_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= ahvm_pkg::ST_IDLE;
			keep_threshold_q    <= ahvm_pkg::KEEP_THRESHOLD_RST;
			average_count_q     <= ahvm_pkg::AVERAGE_COUNT_RST;
			voltage_numerator_q <= ahvm_pkg::VOLTAGE_NUMERATOR_RST;
			slot_index_q        <= '0;
			slot_q              <= '0;
			sample_q            <= '0;
			sum_a_q             <= '0;
			sum_b_q             <= '0;
			count_a_q           <= '0;
			count_b_q           <= '0;
			avg_a_q             <= '0;
			avg_b_q             <= '0;
			committed_q         <= ahvm_pkg::STAGE_OFF;
			pending_q           <= ahvm_pkg::STAGE_OFF;
			temp_q              <= ahvm_pkg::TEMP_RST;
			result_valid_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					ahvm_pkg::CFG_KEEP_THRESHOLD:    keep_threshold_q <= cfg_data[ahvm_pkg::ADC_W-1:0];
					ahvm_pkg::CFG_AVERAGE_COUNT:     average_count_q  <= cfg_data[ahvm_pkg::CNT_W-1:0];
					ahvm_pkg::CFG_VOLTAGE_NUMERATOR: voltage_numerator_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				slot_q   <= slot_index_q;
				sample_q <= adc_sample;
			end
			if (state_q == ahvm_pkg::ST_EXEC) begin
				if (slot_q == ahvm_pkg::SLOT_HEAT_A) begin
					sum_a_q   <= block_done ? '0 : sum_new;
					count_a_q <= block_done ? '0 : cnt_new;
				end
				if (slot_q == ahvm_pkg::SLOT_HEAT_B) begin
					sum_b_q   <= block_done ? '0 : sum_new;
					count_b_q <= block_done ? '0 : cnt_new;
				end
				if (slot_q == ahvm_pkg::SLOT_TEMP) begin
					temp_q <= temp_prod[ahvm_pkg::TEMP_SHIFT +: ahvm_pkg::TEMP_W];
				end
			end
			if (state_q == ahvm_pkg::ST_DIV_WAIT && div_rsp.done) begin
				case (slot_q)
					ahvm_pkg::SLOT_HEAT_A: avg_a_q <= div_rsp.quotient[ahvm_pkg::ADC_W-1:0];
					ahvm_pkg::SLOT_HEAT_B: avg_b_q <= div_rsp.quotient[ahvm_pkg::ADC_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ahvm_pkg::ST_CLASSIFY) begin
				if (stage_new == pending_q) begin
					committed_q <= stage_new;
				end else begin
					pending_q <= stage_new;
				end
			end
			if (load) begin
				slot_index_q   <= (slot_inc >= (ahvm_pkg::SLOT_W+1)'(ahvm_pkg::SLOT_COUNT))
					? '0 : slot_inc[ahvm_pkg::SLOT_W-1:0];
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_slot_q  <= slot_q;
			out_stage_q <= committed_q;
			out_avg_a_q <= avg_a_q;
			out_avg_b_q <= avg_b_q;
			out_temp_q  <= temp_q;
			out_volt_q  <= tree_rsp.minimum;
		end
	end

	ahvm_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ahvm_min_tree u_min_tree (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tree_req),
		.rsp    (tree_rsp)
	);

	assign result_valid = result_valid_q;
	assign sample_slot  = out_slot_q;
	assign heater_stage = out_stage_q;
	assign heater_avg_a = out_avg_a_q;
	assign heater_avg_b = out_avg_b_q;
	assign temperature  = out_temp_q;
	assign min_voltage  = out_volt_q;

`ifndef SYNTHESIS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_index_q < ahvm_pkg::SLOT_W'(ahvm_pkg::SLOT_COUNT))
		else $error("slot index out of range");
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ready |-> !div_rsp.busy && !tree_rsp.busy)
		else $error("sample taken while a shared unit is busy");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ahvm_pkg::ST_DIV_WAIT)
		else $error("divider finished outside its wait state");
	a_tree_done: assert property (@(posedge clk) disable iff (!arst_n)
		tree_rsp.done |-> state_q == ahvm_pkg::ST_TREE)
		else $error("minimum tree finished outside its wait state");
`endif

endmodule
